// File: design/bpc_pkg.sv
// Barometer pressure compensation: shared types and constants.
// Used by the channel interfaces and the top level; depends on nothing.
package bpc_pkg;

   localparam int WORD_W      = 16;
   localparam int COUNT_W     = 10;
   localparam int COUNT_LSB   = 6;
   localparam int PRES_OUT_W  = 11;
   localparam int TEMP_OUT_W  = 12;
   localparam int PIPE_STAGES = 6;

   typedef enum logic [1:0] {
      CSR_OFFSET_COEFF      = 2'd0,
      CSR_PRESSURE_SLOPE    = 2'd1,
      CSR_TEMPERATURE_SLOPE = 2'd2,
      CSR_CROSS_COEFF       = 2'd3
   } csr_index_type;

   // Pcomp is held as an integer with weight 2^-24
   localparam int OFFSET_SHIFT = 21;
   localparam int PSLOPE_SHIFT = 11;
   localparam int TSLOPE_SHIFT = 10;
   localparam int PCOMP_FRAC   = 24;
   localparam logic [33:0] PCOMP_MAX = 34'(1023) << PCOMP_FRAC;

   // pressure = 800 + floor(floor(1040 * X / 2^24) / 1023)
   localparam int PRES_SPAN        = 1040;
   localparam int PRES_DIV         = 1023;
   localparam int PRES_RECIP       = 1025;
   localparam int PRES_RECIP_SHIFT = 20;
   localparam int PRES_BASE        = 800;
   localparam int PRES_MAX         = 1840;

   // temperature = (202160 - 320 * T) / 107, truncated toward zero
   localparam int TEMP_NUM_BASE    = 202160;
   localparam int TEMP_T_SCALE     = 320;
   localparam int TEMP_DIV         = 107;
   localparam int TEMP_RECIP       = 156796;
   localparam int TEMP_RECIP_SHIFT = 24;
   localparam int TEMP_MIN         = -1170;
   localparam int TEMP_MAX         = 1889;

endpackage

// File: design/bpc_req_if.sv
// Input channel: raw pressure and temperature register words.
// Depends on bpc_pkg.
interface bpc_req_if import bpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] pressure_word;
   logic [WORD_W-1:0] temperature_word;

   modport source (output valid, output pressure_word, output temperature_word, input ready);
   modport sink   (input valid, input pressure_word, input temperature_word, output ready);
endinterface

// File: design/bpc_rsp_if.sv
// Result channel: compensated pressure, temperature, counts and clamp flag.
// Depends on bpc_pkg.
interface bpc_rsp_if import bpc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic        [PRES_OUT_W-1:0] pressure_sixteenths;
   logic signed [TEMP_OUT_W-1:0] temperature_sixteenths;
   logic        [COUNT_W-1:0]    pressure_count;
   logic        [COUNT_W-1:0]    temperature_count;
   logic                         clamped;

   modport source (output valid, output pressure_sixteenths, output temperature_sixteenths,
                   output pressure_count, output temperature_count, output clamped,
                   input ready);
   modport sink   (input valid, input pressure_sixteenths, input temperature_sixteenths,
                   input pressure_count, input temperature_count, input clamped,
                   output ready);
endinterface

// File: design/bpc_csr_if.sv
// Configuration write channel: coefficient register index and data.
// Depends on bpc_pkg.
interface bpc_csr_if import bpc_pkg::*; ();
   logic              valid;
   logic              ready;
   csr_index_type     index;
   logic [WORD_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/barometer_pressure_compensation_top.sv
// Barometer pressure compensation, six-stage pipelined datapath.
// Depends on bpc_pkg, bpc_req_if, bpc_rsp_if and bpc_csr_if.
//
// Usage:
//   csr_chan writes the four raw coefficient words (a0, b1, b2, c12); it is
//   always ready and takes one write per cycle. Write only while idle.
//   req_chan carries one item of raw pressure and temperature words; each
//   item yields exactly one item on rsp_chan, in order.
//   An accepted item reaches rsp_chan.valid through the six register stages
//   (multiply stages on the pressure path, one divide-by-constant
//   correction stage per output); one item per cycle is taken while
//   results are drained.
//   Each stage loads whenever it is empty or the stage after it advances,
//   so bubbles close up and a stall of rsp_chan.ready holds each full stage
//   with no empty stage after it; req_chan.ready falls only once all six are full.
//   Reset clears the coefficients to zero and empties the pipeline.
module barometer_pressure_compensation_top import bpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bpc_csr_if.sink   csr_chan,
   bpc_req_if.sink   req_chan,
   bpc_rsp_if.source rsp_chan
);

   logic signed [15:0] a0_ff, b1_ff, b2_ff, c12_ff;

   logic [PIPE_STAGES-1:0] vld_ff;
   logic [PIPE_STAGES-1:0] load;

   // stage 0
   logic        [9:0]  s0_p_in, s0_t_in, s0_p_ff, s0_t_ff;
   logic        [19:0] s0_tp_in, s0_tp_ff;
   logic signed [26:0] s0_b1p_in, s0_b1p_ff, s0_b2t_in, s0_b2t_ff;
   logic        [18:0] s0_tsc;
   logic        [19:0] s0_tnum;
   logic               s0_tneg_in, s0_tneg_ff;
   logic        [17:0] s0_tmag_in, s0_tmag_ff;

   // stage 1
   logic signed [36:0] s1_ctp_in, s1_ctp_ff;
   logic signed [39:0] s1_sum_in, s1_sum_ff;
   logic        [35:0] s1_tprod;
   logic        [10:0] s1_tqe_in, s1_tqe_ff;
   logic        [17:0] s1_tmag_ff;
   logic               s1_tneg_ff;
   logic        [9:0]  s1_p_ff, s1_t_ff;

   // stage 2
   logic signed [40:0] s2_x;
   logic        [33:0] s2_xc_in, s2_xc_ff;
   logic               s2_clamp_in, s2_clamp_ff;
   logic        [17:0] t_rem;
   logic        [10:0] s2_tq;
   logic        [11:0] s2_tq_ext;
   logic        [11:0] s2_temp_in, s2_temp_ff;
   logic        [9:0]  s2_p_ff, s2_t_ff;

   // stage 3
   logic        [44:0] s3_prod;
   logic        [20:0] s3_z_in, s3_z_ff;
   logic               s3_clamp_ff;
   logic        [11:0] s3_temp_ff;
   logic        [9:0]  s3_p_ff, s3_t_ff;

   // stage 4
   logic        [31:0] s4_prod;
   logic        [10:0] s4_qe_in, s4_qe_ff;
   logic        [20:0] s4_z_ff;
   logic               s4_clamp_ff;
   logic        [11:0] s4_temp_ff;
   logic        [9:0]  s4_p_ff, s4_t_ff;

   // stage 5 (output register)
   logic        [20:0] p_rem;
   logic        [10:0] s5_pres_in, s5_pres_ff;
   logic               s5_clamp_ff;
   logic        [11:0] s5_temp_ff;
   logic        [9:0]  s5_p_ff, s5_t_ff;

   // coefficient registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_ff  <= '0;
         b1_ff  <= '0;
         b2_ff  <= '0;
         c12_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_OFFSET_COEFF:      a0_ff  <= $signed(csr_chan.data);
            CSR_PRESSURE_SLOPE:    b1_ff  <= $signed(csr_chan.data);
            CSR_TEMPERATURE_SLOPE: b2_ff  <= $signed(csr_chan.data);
            CSR_CROSS_COEFF:       c12_ff <= $signed(csr_chan.data);
            default: ;
         endcase
      end
   end

   // pipeline flow control
   always_comb begin
      load[PIPE_STAGES-1] = !vld_ff[PIPE_STAGES-1] || rsp_chan.ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         load[i] = !vld_ff[i] || load[i+1];
      end
   end

   assign req_chan.ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int i = 1; i < PIPE_STAGES; i++) begin
            if (load[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // stage 0: counts, products with the counts, temperature numerator
   assign s0_p_in    = req_chan.pressure_word[WORD_W-1:COUNT_LSB];
   assign s0_t_in    = req_chan.temperature_word[WORD_W-1:COUNT_LSB];
   assign s0_tp_in   = 20'(s0_p_in) * 20'(s0_t_in);
   assign s0_b1p_in  = 27'(b1_ff) * 27'($signed({1'b0, s0_p_in}));
   assign s0_b2t_in  = 27'(b2_ff) * 27'($signed({1'b0, s0_t_in}));
   assign s0_tsc     = 19'(s0_t_in) * 19'(TEMP_T_SCALE);
   assign s0_tnum    = 20'(TEMP_NUM_BASE) - {1'b0, s0_tsc};
   assign s0_tneg_in = s0_tnum[19];
   assign s0_tmag_in = s0_tneg_in ? 18'(-s0_tnum) : 18'(s0_tnum);

   // stage 1: cross term, partial sum, temperature quotient estimate
   assign s1_ctp_in = 37'(c12_ff) * 37'($signed({1'b0, s0_tp_ff}));
   assign s1_sum_in = (40'(a0_ff) <<< OFFSET_SHIFT) + (40'(s0_b1p_ff) <<< PSLOPE_SHIFT)
                    + (40'(s0_b2t_ff) <<< TSLOPE_SHIFT);
   assign s1_tprod  = 36'(s0_tmag_ff) * 36'(TEMP_RECIP);
   assign s1_tqe_in = s1_tprod[TEMP_RECIP_SHIFT +: 11];

   // stage 2: final sum and clamp, temperature correction and sign
   assign s2_x = 41'(s1_sum_ff) + 41'(s1_ctp_ff);

   always_comb begin
      if (s2_x[40]) begin
         s2_xc_in    = '0;
         s2_clamp_in = 1'b1;
      end else if (s2_x[39:0] > 40'(PCOMP_MAX)) begin
         s2_xc_in    = PCOMP_MAX;
         s2_clamp_in = 1'b1;
      end else begin
         s2_xc_in    = s2_x[33:0];
         s2_clamp_in = 1'b0;
      end
   end

   assign t_rem      = s1_tmag_ff - 18'(s1_tqe_ff) * 18'(TEMP_DIV);
   assign s2_tq      = s1_tqe_ff + 11'(t_rem >= 18'(TEMP_DIV));
   assign s2_tq_ext  = {1'b0, s2_tq};
   assign s2_temp_in = s1_tneg_ff ? -s2_tq_ext : s2_tq_ext;

   // stage 3: scale to the pressure span
   assign s3_prod = 45'(s2_xc_ff) * 45'(PRES_SPAN);
   assign s3_z_in = s3_prod[PCOMP_FRAC +: 21];

   // stage 4: quotient estimate by reciprocal of 1023
   assign s4_prod  = 32'(s3_z_ff) * 32'(PRES_RECIP);
   assign s4_qe_in = s4_prod[PRES_RECIP_SHIFT +: 11];

   // stage 5: quotient correction and offset
   assign p_rem      = s4_z_ff - 21'(s4_qe_ff) * 21'(PRES_DIV);
   assign s5_pres_in = 11'(PRES_BASE) + s4_qe_ff + 11'(p_rem >= 21'(PRES_DIV));

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s0_p_ff    <= s0_p_in;
         s0_t_ff    <= s0_t_in;
         s0_tp_ff   <= s0_tp_in;
         s0_b1p_ff  <= s0_b1p_in;
         s0_b2t_ff  <= s0_b2t_in;
         s0_tneg_ff <= s0_tneg_in;
         s0_tmag_ff <= s0_tmag_in;
      end
      if (load[1]) begin
         s1_ctp_ff  <= s1_ctp_in;
         s1_sum_ff  <= s1_sum_in;
         s1_tqe_ff  <= s1_tqe_in;
         s1_tmag_ff <= s0_tmag_ff;
         s1_tneg_ff <= s0_tneg_ff;
         s1_p_ff    <= s0_p_ff;
         s1_t_ff    <= s0_t_ff;
      end
      if (load[2]) begin
         s2_xc_ff    <= s2_xc_in;
         s2_clamp_ff <= s2_clamp_in;
         s2_temp_ff  <= s2_temp_in;
         s2_p_ff     <= s1_p_ff;
         s2_t_ff     <= s1_t_ff;
      end
      if (load[3]) begin
         s3_z_ff     <= s3_z_in;
         s3_clamp_ff <= s2_clamp_ff;
         s3_temp_ff  <= s2_temp_ff;
         s3_p_ff     <= s2_p_ff;
         s3_t_ff     <= s2_t_ff;
      end
      if (load[4]) begin
         s4_qe_ff    <= s4_qe_in;
         s4_z_ff     <= s3_z_ff;
         s4_clamp_ff <= s3_clamp_ff;
         s4_temp_ff  <= s3_temp_ff;
         s4_p_ff     <= s3_p_ff;
         s4_t_ff     <= s3_t_ff;
      end
      if (load[5]) begin
         s5_pres_ff  <= s5_pres_in;
         s5_clamp_ff <= s4_clamp_ff;
         s5_temp_ff  <= s4_temp_ff;
         s5_p_ff     <= s4_p_ff;
         s5_t_ff     <= s4_t_ff;
      end
   end

   assign rsp_chan.valid                  = vld_ff[PIPE_STAGES-1];
   assign rsp_chan.pressure_sixteenths    = s5_pres_ff;
   assign rsp_chan.temperature_sixteenths = $signed(s5_temp_ff);
   assign rsp_chan.pressure_count         = s5_p_ff;
   assign rsp_chan.temperature_count      = s5_t_ff;
   assign rsp_chan.clamped                = s5_clamp_ff;

`ifndef SYNTH
   a_no_bubble_drop: assert property (@(posedge clock) disable iff (reset)
      !reset && vld_ff[0] && !vld_ff[1] |=> vld_ff[1])
      else $error("item lost between first and second stage");

   a_temp_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> t_rem < 18'(2 * TEMP_DIV))
      else $error("temperature quotient estimate out of range");

   a_pres_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> p_rem < 21'(2 * PRES_DIV))
      else $error("pressure quotient estimate out of range");

   a_pres_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.pressure_sixteenths >= 11'(PRES_BASE)
                      && rsp_chan.pressure_sixteenths <= 11'(PRES_MAX))
      else $error("pressure result out of range");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.temperature_sixteenths >= 12'(TEMP_MIN)
                      && rsp_chan.temperature_sixteenths <= 12'(TEMP_MAX))
      else $error("temperature result out of range");

   a_clamp_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.clamped |->
         rsp_chan.pressure_sixteenths == 11'(PRES_BASE)
         || rsp_chan.pressure_sixteenths == 11'(PRES_MAX))
      else $error("clamped item does not sit at a range limit");
`endif

endmodule

// File: verif/tb.sv
// Testbench for the barometer pressure compensation pipeline: loads coefficient
// sets, drives raw pressure and temperature words and checks every reading in order.
// Depends on bpc_pkg, the three channel interfaces and barometer_pressure_compensation_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpc_pkg::*;

   localparam int     CYCLE_LIMIT = 400000;
   localparam longint PCOMP_FULL  = longint'(1023) << 24;

   typedef struct {
      logic        [PRES_OUT_W-1:0] pressure;
      logic signed [TEMP_OUT_W-1:0] temperature;
      logic        [COUNT_W-1:0]    pressure_count;
      logic        [COUNT_W-1:0]    temperature_count;
      logic                         clamped;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpc_csr_if csr_chan ();
   bpc_req_if req_chan ();
   bpc_rsp_if rsp_chan ();

   barometer_pressure_compensation_top dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic signed [WORD_W-1:0] coeff_word [4];
   reading_type pending_readings [$];
   int error_count   = 0;
   int cycle_count   = 0;
   bit req_gaps_on   = 1'b1;
   bit rsp_gaps_on   = 1'b1;
   bit hold_off_req  = 1'b0;
   bit hold_off_seen = 1'b0;
   int stall_left    = 0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic reading_type compensate(input logic [WORD_W-1:0] pw,
                                              input logic [WORD_W-1:0] tw);
      reading_type r;
      longint p, t, a0, b1, b2, c12, x;
      p   = longint'(pw[15:6]);
      t   = longint'(tw[15:6]);
      a0  = longint'(coeff_word[CSR_OFFSET_COEFF]);
      b1  = longint'(coeff_word[CSR_PRESSURE_SLOPE]);
      b2  = longint'(coeff_word[CSR_TEMPERATURE_SLOPE]);
      c12 = longint'(coeff_word[CSR_CROSS_COEFF]);
      x   = a0 * 2097152 + b1 * 2048 * p + c12 * t * p + b2 * 1024 * t;
      r.clamped = 1'b0;
      if (x < 0) begin
         x = 0;
         r.clamped = 1'b1;
      end else if (x > PCOMP_FULL) begin
         x = PCOMP_FULL;
         r.clamped = 1'b1;
      end
      r.pressure          = PRES_OUT_W'(800 + (x * 1040) / PCOMP_FULL);
      r.temperature       = TEMP_OUT_W'((1010800 - 1600 * t) / 535);
      r.pressure_count    = COUNT_W'(p);
      r.temperature_count = COUNT_W'(t);
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected item, expected none actual pressure %0d", $time,
                     rsp_chan.pressure_sixteenths);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("pressure", want.pressure, rsp_chan.pressure_sixteenths);
            check_field("temperature", want.temperature, rsp_chan.temperature_sixteenths);
            check_field("pressure_count", want.pressure_count, rsp_chan.pressure_count);
            check_field("temperature_count", want.temperature_count,
                        rsp_chan.temperature_count);
            check_field("clamped", want.clamped, rsp_chan.clamped);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off_req != hold_off_seen) begin
         hold_off_seen = hold_off_req;
         stall_left    = 250;
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gaps_on && $urandom_range(0, 99) < 20) begin
         stall_left = idle_length() - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_sample(input logic [WORD_W-1:0] pw, input logic [WORD_W-1:0] tw);
      int gap = 0;
      if (req_gaps_on && $urandom_range(0, 99) < 35) gap = idle_length();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.pressure_word    <= pw;
      req_chan.temperature_word <= tw;
      do @(posedge clock); while (!req_chan.ready);
      pending_readings.push_back(compensate(pw, tw));
   endtask

   task automatic quiesce();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic put_coeff(input csr_index_type idx, input logic [WORD_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      coeff_word[idx] = value;
   endtask

   task automatic load_coeffs(input logic [WORD_W-1:0] a0, input logic [WORD_W-1:0] b1,
                              input logic [WORD_W-1:0] b2, input logic [WORD_W-1:0] c12);
      put_coeff(CSR_OFFSET_COEFF, a0);
      put_coeff(CSR_PRESSURE_SLOPE, b1);
      put_coeff(CSR_TEMPERATURE_SLOPE, b2);
      put_coeff(CSR_CROSS_COEFF, c12);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic test_reset_coeffs();
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'h003F, 16'hFFC0);
      send_sample(16'hFFC0, 16'h003F);
      send_sample(16'h8000, 16'h7C80);
      quiesce();
   endtask

   task automatic test_clamp_edges();
      load_coeffs(16'd8184, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h1234, 16'h5678);
      quiesce();
      load_coeffs(16'd8185, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h1234, 16'h5678);
      quiesce();
      load_coeffs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h1234, 16'h5678);
      quiesce();
      load_coeffs(16'h0000, 16'h8000, 16'h0000, 16'h0000);
      send_sample(16'h003F, 16'h0000);
      send_sample(16'h0040, 16'h0000);
      quiesce();
   endtask

   task automatic test_typical_coeffs();
      load_coeffs(16'h3ECE, 16'hB3F9, 16'hC517, 16'h33C8);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'h6700, 16'h8100);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'h4000, 16'h7C80);
      quiesce();
   endtask

   task automatic test_coeff_extremes();
      load_coeffs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'h0000, 16'hFFFF);
      quiesce();
      load_coeffs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 16'h0000);
      quiesce();
      load_coeffs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_sample(16'hFFFF, 16'hFFFF);
      quiesce();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         if ($urandom_range(0, 99) < 60)
            load_coeffs(16'(16078 + int'($urandom_range(0, 2000)) - 1000),
                        16'(-19462 + int'($urandom_range(0, 4000)) - 2000),
                        16'(-15081 + int'($urandom_range(0, 4000)) - 2000),
                        16'(13256 + int'($urandom_range(0, 6000)) - 3000));
         else
            load_coeffs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         req_gaps_on = (phase % 3) != 0;
         rsp_gaps_on <= (phase % 4) != 1;
         repeat (80) send_sample(16'($urandom), 16'($urandom));
         quiesce();
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   task automatic test_backpressure();
      load_coeffs(16'h3ECE, 16'hB3F9, 16'hC517, 16'h33C8);
      req_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      hold_off_req <= ~hold_off_req;
      repeat (40) send_sample(16'($urandom), 16'($urandom));
      quiesce();
      req_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   initial begin
      coeff_word                = '{default: '0};
      csr_chan.valid            = 1'b0;
      csr_chan.index            = CSR_OFFSET_COEFF;
      csr_chan.data             = '0;
      req_chan.valid            = 1'b0;
      req_chan.pressure_word    = '0;
      req_chan.temperature_word = '0;
      rsp_chan.ready            = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_coeffs();
      test_clamp_edges();
      test_typical_coeffs();
      test_coeff_extremes();
      test_random_traffic();
      test_backpressure();
      repeat (PIPE_STAGES * 3) @(posedge clock);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// File: files.f
design/bpc_pkg.sv
design/bpc_req_if.sv
design/bpc_rsp_if.sv
design/bpc_csr_if.sv
design/barometer_pressure_compensation_top.sv
verif/tb.sv
